[design/connection_rate_limiter_top_assert.svh]
// Assertion macros used by the rate limiter top level.
`ifndef CONNECTION_RATE_LIMITER_TOP_ASSERT_SVH
`define CONNECTION_RATE_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CRL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/crl_pkg.sv]
// Types and constants of the connection rate limiter.
`timescale 1ns / 1ps
package crl_pkg;

    localparam int TABLE_ENTRIES = 64;                  // table depth, one cell per entry
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic OP_CONN = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] CFG_WINDOW    = 8'd0;
    localparam logic [7:0] CFG_MAX_REQ   = 8'd1;
    localparam logic [7:0] CFG_BAN       = 8'd2;
    localparam logic [7:0] CFG_PORT_CNT  = 8'd3;
    localparam logic [7:0] CFG_PORT_A    = 8'd4;
    localparam logic [7:0] CFG_PORT_B    = 8'd5;
    localparam logic [7:0] CFG_PORT_C    = 8'd6;
    localparam logic [7:0] CFG_PORT_D    = 8'd7;

    localparam logic [16:0] BAN_MARK = 17'h10000;

    typedef enum logic [2:0] {
        V_UNMON  = 3'd0,
        V_FIRST  = 3'd1,
        V_COUNT  = 3'd2,
        V_BANNED = 3'd3,
        V_STILL  = 3'd4,
        V_FULL   = 3'd5
    } t_verdict;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    // lookup token walking the cell row
    typedef struct packed {
        logic             vld;
        logic [31:0]      ip;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [16:0]      hit_val;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } t_token;

    // broadcast control to every cell
    typedef struct packed {
        logic             tick;
        logic [31:0]      now_next;
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        logic             set_key;
        logic [31:0]      key;
        logic [16:0]      val;
        logic             exp_en;
        logic [31:0]      expiry;
    } t_cell_ctl;

endpackage

[design/crl_cell.sv]
// One table entry of the rate limiter plus one stage of the lookup chain.
`timescale 1ns / 1ps
module crl_cell
    import crl_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_token    i_tok,
    output t_token    o_tok
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic        r_valid;
    logic [31:0] r_key;
    logic [16:0] r_val;
    logic [31:0] r_exp;
    t_token      r_tok;
    t_token      n_tok;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld) begin
            if (r_valid) begin
                if (!i_tok.hit && r_key == i_tok.ip) begin
                    n_tok.hit     = 1'b1;
                    n_tok.hit_idx = MY_IDX;
                    n_tok.hit_val = r_val;
                end
            end else if (!i_tok.free) begin
                n_tok.free     = 1'b1;
                n_tok.free_idx = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_ctl.tick && r_valid && r_exp == i_ctl.now_next) begin
                r_valid <= 1'b0;
            end else if (i_ctl.wr && i_ctl.wr_idx == MY_IDX && i_ctl.set_key) begin
                r_valid <= 1'b1;
            end
        end
    end

    // entry payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_ctl.wr_idx == MY_IDX) begin
            r_val <= i_ctl.val;
            if (i_ctl.set_key) begin
                r_key <= i_ctl.key;
            end
            if (i_ctl.exp_en) begin
                r_exp <= i_ctl.expiry;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

[design/connection_rate_limiter_top.sv]
// Top level of the per-source connection rate limiter.
`timescale 1ns / 1ps
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   -------------------------------------
//  input     i_valid / o_ready         i_opcode, i_source_ip, i_dest_port
//  result    o_valid / i_ready         o_close_conn, o_verdict, o_count_after
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  A tick request advances the tick count and gives no result. A connection
//  to an unwatched port is answered in the cycle after acceptance. A watched
//  connection sends a lookup token down the row of TABLE_ENTRIES cells, one
//  cell per cycle; the chain length sets the rate. Reset (synchronous, active
//  low) clears all entry valid bits and the tick count. Input is held off
//  while a lookup runs or a result waits on i_ready.
//
module connection_rate_limiter_top
    import crl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // requests
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [31:0] i_source_ip,
    input  logic [15:0] i_dest_port,
    // results
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_close_conn,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_count_after,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // config registers
    logic [15:0] r_window, r_max_req, r_ban;
    logic [2:0]  r_port_cnt;
    logic [15:0] r_port_a, r_port_b, r_port_c, r_port_d;

    logic [31:0] r_now;
    t_state      r_state, n_state;

    logic        r_out_vld;
    logic        r_out_close;
    t_verdict    r_out_verdict;
    logic [15:0] r_out_count;
    logic        n_out_load;
    logic        n_out_close;
    t_verdict    n_out_verdict;
    logic [15:0] n_out_count;

    t_token      tok [0:TABLE_ENTRIES];
    t_token      tok_end;
    t_cell_ctl   ctl;

    logic        in_acc;
    logic        watched;
    logic [2:0]  n_ports;
    logic [15:0] win1, ban1;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE) && !r_out_vld;
    assign in_acc      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= 16'd60;
            r_max_req  <= 16'd20;
            r_ban      <= 16'd80;
            r_port_cnt <= 3'd1;
            r_port_a   <= 16'd80;
            r_port_b   <= 16'd0;
            r_port_c   <= 16'd0;
            r_port_d   <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW:   r_window   <= i_cfg_data;
                CFG_MAX_REQ:  r_max_req  <= i_cfg_data;
                CFG_BAN:      r_ban      <= i_cfg_data;
                CFG_PORT_CNT: r_port_cnt <= i_cfg_data[2:0];
                CFG_PORT_A:   r_port_a   <= i_cfg_data;
                CFG_PORT_B:   r_port_b   <= i_cfg_data;
                CFG_PORT_C:   r_port_c   <= i_cfg_data;
                CFG_PORT_D:   r_port_d   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // port filter; counts above four act as four
    assign n_ports = (r_port_cnt > 3'd4) ? 3'd4 : r_port_cnt;
    assign watched = (n_ports == 3'd0)
                  || (r_port_a == i_dest_port)
                  || (n_ports >= 3'd2 && r_port_b == i_dest_port)
                  || (n_ports >= 3'd3 && r_port_c == i_dest_port)
                  || (n_ports >= 3'd4 && r_port_d == i_dest_port);

    assign win1 = (r_window == 16'd0) ? 16'd1 : r_window;
    assign ban1 = (r_ban == 16'd0) ? 16'd1 : r_ban;

    // token injection at the head of the row
    always_comb begin
        tok[0]          = '0;
        tok[0].vld      = in_acc && (i_opcode == OP_CONN) && watched;
        tok[0].ip       = i_source_ip;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            crl_cell #(.CELL_ID(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_tok   (tok[g]),
                .o_tok   (tok[g+1])
            );
        end
    endgenerate

    assign tok_end = tok[TABLE_ENTRIES];

    // decision on the returning token, entry write broadcast
    always_comb begin
        ctl           = '0;
        ctl.tick      = in_acc && (i_opcode == OP_TICK);
        ctl.now_next  = r_now + 32'd1;
        ctl.key       = tok_end.ip;
        n_out_load    = 1'b0;
        n_out_close   = 1'b0;
        n_out_verdict = V_UNMON;
        n_out_count   = 16'd0;
        n_state       = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_opcode == OP_CONN) begin
                    if (watched) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_out_load = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                if (tok_end.vld) begin
                    n_state    = S_IDLE;
                    n_out_load = 1'b1;
                    if (!tok_end.hit) begin
                        if (!tok_end.free) begin
                            n_out_close   = 1'b1;
                            n_out_verdict = V_FULL;
                        end else begin
                            ctl.wr        = 1'b1;
                            ctl.wr_idx    = tok_end.free_idx;
                            ctl.set_key   = 1'b1;
                            ctl.val       = 17'd1;
                            ctl.exp_en    = 1'b1;
                            ctl.expiry    = r_now + {16'd0, win1};
                            n_out_verdict = V_FIRST;
                            n_out_count   = 16'd1;
                        end
                    end else if (tok_end.hit_val[16]) begin
                        n_out_close   = 1'b1;
                        n_out_verdict = V_STILL;
                    end else if (tok_end.hit_val[15:0] >= r_max_req) begin
                        ctl.wr        = 1'b1;
                        ctl.wr_idx    = tok_end.hit_idx;
                        ctl.val       = BAN_MARK;
                        ctl.exp_en    = 1'b1;
                        ctl.expiry    = r_now + {16'd0, ban1};
                        n_out_close   = 1'b1;
                        n_out_verdict = V_BANNED;
                    end else begin
                        ctl.wr        = 1'b1;
                        ctl.wr_idx    = tok_end.hit_idx;
                        ctl.val       = {1'b0, tok_end.hit_val[15:0] + 16'd1};
                        n_out_verdict = V_COUNT;
                        n_out_count   = tok_end.hit_val[15:0] + 16'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= 32'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.tick) begin
                r_now <= ctl.now_next;
            end
            if (n_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_out_close   <= n_out_close;
            r_out_verdict <= n_out_verdict;
            r_out_count   <= n_out_count;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_close_conn  = r_out_close;
    assign o_verdict     = r_out_verdict;
    assign o_count_after = r_out_count;

`include "connection_rate_limiter_top_assert.svh"

    `CRL_ASSERT_IMPL(a_tok_in_search, tok_end.vld, r_state == S_SEARCH, "token outside lookup")
    `CRL_ASSERT_IMPL(a_no_write_tick, ctl.wr, !ctl.tick, "entry write during tick")
    `CRL_ASSERT_IMPL(a_full_closes, o_valid && o_verdict == V_FULL, o_close_conn,
                     "table full without close")
    `CRL_ASSERT_NEXT(a_lookup_starts, tok[0].vld, r_state == S_SEARCH && !o_ready,
                     "lookup did not start")

endmodule
